// ===== rtl/crk_pkg.sv =====
// Shared types and codes for the region kind table.
package crk_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 512;
    localparam int ADDR_W = 64;
    localparam int ENTRY_INDEX_W = 9;

    // Request codes on the input channel
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_MERGED  = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;

    // Operation class decided by the front end
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    // Classified command held in the queue
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_end;
        logic              kind;
    } cmd_t;

    // One stored region
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic              kind;
    } entry_t;

endpackage

// ===== rtl/crk_if.sv =====
// Request and response channel interfaces of the region kind table.
interface crk_req_if;
    import crk_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   range_end;
    logic                new_kind;

    modport source (output valid, req_type, address, range_end, new_kind, input ready);
    modport sink   (input valid, req_type, address, range_end, new_kind, output ready);
endinterface

interface crk_rsp_if;
    import crk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic                     found;
    logic                     found_kind;
    logic [ENTRY_INDEX_W-1:0] entry_index;

    modport source (output valid, status, found, found_kind, entry_index, input ready);
    modport sink   (input valid, status, found, found_kind, entry_index, output ready);
endinterface

// ===== rtl/crk_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module crk_front
    import crk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    crk_req_if.sink   req,
    output logic      q_valid,
    input  logic      q_ready,
    output cmd_t      q_cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push, pop;

    // Classification: bad adds and the unused code become rejects
    always_comb
    begin
        cls.address   = req.address;
        cls.range_end = req.range_end;
        cls.kind      = req.new_kind;
        unique case (req.req_type)
            REQ_CLEAR:  cls.op = OP_CLEAR;
            REQ_ADD:    cls.op = (req.address == '0 || req.range_end <= req.address)
                                 ? OP_REJECT : OP_ADD;
            REQ_LOOKUP: cls.op = OP_LOOKUP;
            default:    cls.op = OP_REJECT;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = fifo_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== rtl/crk_back.sv =====
// Back end: owns the region memory, runs adds and lookup scans, drives results.
module crk_back
    import crk_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    crk_rsp_if.source rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HINT = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hint_valid_reg, hint_valid_next;
    logic [IDX_W-1:0]  hint_reg, hint_next;
    logic [ADDR_W-1:0] last_start_reg, last_start_next;
    logic [ADDR_W-1:0] last_end_reg, last_end_next;
    logic              last_kind_reg, last_kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic              res_found_reg, res_found_next;
    logic              res_kind_reg, res_kind_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic              out_found_reg, out_found_next;
    logic              out_kind_reg, out_kind_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;

    entry_t            mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic              take, hint_ok, full, in_range, below, scan_last;
    logic [IDX_W-1:0]  last_idx;
    logic [CNT_W-1:0]  scan_inc;
    logic [IDX_W+ENTRY_INDEX_W-1:0] idx_ext;

    assign q_ready   = (state_reg == S_IDLE);
    assign take      = q_valid && q_ready;
    assign hint_ok   = hint_valid_reg && (CNT_W'(hint_reg) < count_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign last_idx  = IDX_W'(count_reg - 1'b1);
    assign below     = addr_reg < rd_data_reg.start_addr;
    assign in_range  = !below && (addr_reg < rd_data_reg.end_addr);
    assign scan_inc  = CNT_W'(scan_reg) + 1'b1;
    assign scan_last = (scan_inc >= count_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hint_valid_next = hint_valid_reg;
        hint_next       = hint_reg;
        last_start_next = last_start_reg;
        last_end_next   = last_end_reg;
        last_kind_next  = last_kind_reg;
        addr_next       = addr_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_kind_next   = res_kind_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        rd_addr         = scan_reg;
        wr_en           = 1'b0;
        wr_addr         = last_idx;
        wr_data         = '{start_addr: q_cmd.address, end_addr: q_cmd.range_end,
                            kind: q_cmd.kind};

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    res_status_next = ST_DONE;
                    res_found_next  = 1'b0;
                    res_kind_next   = 1'b0;
                    res_idx_next    = '0;
                    addr_next       = q_cmd.address;
                    state_next      = S_DONE;
                    unique case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            hint_valid_next = 1'b0;
                            hint_next       = '0;
                        end
                        OP_ADD:
                        begin
                            if (count_reg != '0 && last_kind_reg == q_cmd.kind &&
                                q_cmd.address <= last_end_reg)
                            begin
                                // merge into the last entry
                                wr_en           = 1'b1;
                                wr_addr         = last_idx;
                                wr_data.start_addr = last_start_reg;
                                wr_data.kind    = last_kind_reg;
                                wr_data.end_addr = (q_cmd.range_end > last_end_reg)
                                                   ? q_cmd.range_end : last_end_reg;
                                last_end_next   = wr_data.end_addr;
                                res_status_next = ST_MERGED;
                                res_idx_next    = last_idx;
                            end
                            else if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = IDX_W'(count_reg);
                                last_start_next = q_cmd.address;
                                last_end_next   = q_cmd.range_end;
                                last_kind_next  = q_cmd.kind;
                                count_next      = count_reg + 1'b1;
                                res_idx_next    = IDX_W'(count_reg);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (hint_ok)
                            begin
                                rd_addr    = hint_reg;
                                state_next = S_HINT;
                            end
                            else if (count_reg != '0)
                            begin
                                rd_addr    = '0;
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_status_next = ST_MISS;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_HINT:
            begin
                if (in_range)
                begin
                    res_found_next = 1'b1;
                    res_kind_next  = rd_data_reg.kind;
                    res_idx_next   = hint_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    rd_addr    = '0;
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one entry per cycle, stop at first start above the address
                if (below)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end
                else if (in_range)
                begin
                    res_found_next  = 1'b1;
                    res_kind_next   = rd_data_reg.kind;
                    res_idx_next    = scan_reg;
                    hint_valid_next = 1'b1;
                    hint_next       = scan_reg;
                    state_next      = S_DONE;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr   = IDX_W'(scan_inc);
                    scan_next = IDX_W'(scan_inc);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_kind_next   = res_kind_reg;
                    out_idx_next    = res_idx_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            hint_valid_reg <= 1'b0;
            hint_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hint_valid_reg <= hint_valid_next;
            hint_reg       <= hint_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_start_reg <= last_start_next;
        last_end_reg   <= last_end_next;
        last_kind_reg  <= last_kind_next;
        addr_reg       <= addr_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_kind_reg   <= res_kind_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_kind_reg   <= out_kind_next;
        out_idx_reg    <= out_idx_next;
    end

    // Region memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign idx_ext         = {{ENTRY_INDEX_W{1'b0}}, out_idx_reg};
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.found_kind  = out_kind_reg;
    assign rsp.entry_index = idx_ext[ENTRY_INDEX_W-1:0];

endmodule

// ===== rtl/coalescing_region_kind_table_unit.sv =====
// Top level of the coalescing region kind table.
// Path from the request transfer to the offered result: clear, add and rejected requests
// go straight to the done state, a lookup first reads the hinted entry when a valid hint
// exists, and any other lookup, or one whose hint probe missed, scans the entries one at a
// time, since the region memory has a single registered read port.
// Requests queue two deep in front of the table engine, and a finished result sits in an
// output register while the next request is taken; response stalls hold the done state.
module coalescing_region_kind_table_unit
    import crk_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    crk_req_if.sink   req,
    crk_rsp_if.source rsp
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    crk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    crk_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .rsp     (rsp)
    );

`ifndef ASSERT_OFF
    a_found_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == ST_DONE)
        else $error("hit result without done status");

    a_kind_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> !rsp.found_kind)
        else $error("kind reported without a hit");

    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_cmd))
        else $error("queued command lost while back end busy");
`endif

endmodule

// ===== bench/crk_table_checker.sv =====
// Watches both channels of the region table, predicts each response and compares.
`timescale 1ns / 100ps

module crk_table_checker
    import crk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    crk_req_if   req,
    crk_rsp_if   rsp,
    output int   fail_count,
    output int   pending_count
);

    typedef struct packed {
        logic [2:0]               status;
        logic                     found;
        logic                     found_kind;
        logic [ENTRY_INDEX_W-1:0] entry_index;
    } answer_t;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    // Shadow copy of the table
    logic [ADDR_W-1:0] shadow_start [DEPTH];
    logic [ADDR_W-1:0] shadow_end   [DEPTH];
    logic              shadow_kind  [DEPTH];
    int unsigned       shadow_count;
    logic              shadow_hint_valid;
    int unsigned       shadow_hint;

    answer_t expected_answers [$];

    function automatic answer_t make_answer(logic [2:0] st, logic f, logic k, int unsigned idx);
        answer_t r;
        r.status      = st;
        r.found       = f;
        r.found_kind  = k;
        r.entry_index = idx[ENTRY_INDEX_W-1:0];
        return r;
    endfunction

    // Apply one request to the shadow table and return what the block should answer
    task automatic table_apply(input logic [1:0] kind_of_req, input logic [ADDR_W-1:0] a,
                               input logic [ADDR_W-1:0] e, input logic k,
                               output answer_t r);
        int unsigned p;
        int unsigned i;
        bit          hit;
        hit = 0;
        r = make_answer(ST_INVALID, 1'b0, 1'b0, 0);
        case (kind_of_req)
            REQ_CLEAR:
            begin
                shadow_count      = 0;
                shadow_hint_valid = 1'b0;
                shadow_hint       = 0;
                r = make_answer(ST_DONE, 1'b0, 1'b0, 0);
            end
            REQ_ADD:
            begin
                if (a == '0 || e <= a)
                    r = make_answer(ST_INVALID, 1'b0, 1'b0, 0);
                else
                begin
                    // merge into the last entry when kinds agree and ranges touch
                    if (shadow_count > 0)
                    begin
                        p = shadow_count - 1;
                        if (shadow_kind[p] == k && a <= shadow_end[p])
                        begin
                            if (e > shadow_end[p])
                                shadow_end[p] = e;
                            r = make_answer(ST_MERGED, 1'b0, 1'b0, p);
                            hit = 1;
                        end
                    end
                    if (!hit)
                    begin
                        if (shadow_count >= DEPTH)
                            r = make_answer(ST_FULL, 1'b0, 1'b0, 0);
                        else
                        begin
                            shadow_start[shadow_count] = a;
                            shadow_end[shadow_count]   = e;
                            shadow_kind[shadow_count]  = k;
                            r = make_answer(ST_DONE, 1'b0, 1'b0, shadow_count);
                            shadow_count++;
                        end
                    end
                end
            end
            REQ_LOOKUP:
            begin
                r = make_answer(ST_MISS, 1'b0, 1'b0, 0);
                // hinted entry first, then an ordered scan with early stop
                if (shadow_hint_valid && shadow_hint < shadow_count &&
                    a >= shadow_start[shadow_hint] && a < shadow_end[shadow_hint])
                    r = make_answer(ST_DONE, 1'b1, shadow_kind[shadow_hint], shadow_hint);
                else
                begin
                    for (i = 0; i < shadow_count && !hit; i++)
                    begin
                        if (a < shadow_start[i])
                            break;
                        if (a < shadow_end[i])
                        begin
                            shadow_hint_valid = 1'b1;
                            shadow_hint       = i;
                            r = make_answer(ST_DONE, 1'b1, shadow_kind[i], i);
                            hit = 1;
                        end
                    end
                end
            end
            default:
                r = make_answer(ST_INVALID, 1'b0, 1'b0, 0);
        endcase
    endtask

    // Responses are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            shadow_count      = 0;
            shadow_hint_valid = 1'b0;
            shadow_hint       = 0;
            expected_answers.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = make_answer(rsp.status, rsp.found, rsp.found_kind, rsp.entry_index);
                if (expected_answers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response with nothing outstanding: %h", $realtime, got);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch st %0d/%0d found %0d/%0d kind %0d/%0d idx %0d/%0d",
                                     $realtime, want.status, got.status, want.found, got.found,
                                     want.found_kind, got.found_kind,
                                     want.entry_index, got.entry_index);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                table_apply(req.req_type, req.address, req.range_end, req.new_kind, want);
                expected_answers.push_back(want);
            end
            pending_count = expected_answers.size();
        end
    end

endmodule

// ===== bench/coalescing_region_kind_table_unit_test.sv =====
// Stimulus and verdict for the coalescing region kind table.
`timescale 1ns / 100ps

module coalescing_region_kind_table_unit_test;
    import crk_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    bit   calm;
    int   items_sent;

    logic [ADDR_W-1:0] boundaries [$];

    crk_req_if req_ch ();
    crk_rsp_if rsp_ch ();

    coalescing_region_kind_table_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    crk_table_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #8000000;
        $display("coalescing_region_kind_table_unit_test: errors");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [ADDR_W-1:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // One request transfer; inputs move only on the falling edge
    task automatic send_item(input logic [1:0] t, input logic [ADDR_W-1:0] a,
                             input logic [ADDR_W-1:0] e, input logic k);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.req_type  = t;
        req_ch.address   = a;
        req_ch.range_end = e;
        req_ch.new_kind  = k;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
        if (t == REQ_CLEAR)
            boundaries.delete();
        if (t == REQ_ADD && a != '0 && e > a)
        begin
            boundaries.push_back(a);
            boundaries.push_back(e);
        end
    endtask

    task automatic send_lookup();
        logic [ADDR_W-1:0] a;
        if (boundaries.size() > 0 && $urandom_range(0, 9) < 8)
            a = boundaries[$urandom_range(0, boundaries.size() - 1)] + $urandom_range(0, 2) - 1;
        else if ($urandom_range(0, 1))
            a = wide_random();
        else
            a = $urandom_range(0, 5000);
        send_item(REQ_LOOKUP, a, wide_random(), $urandom_range(0, 1));
    endtask

    // Response side stalls per transfer
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] e;
        logic              k;
        int                n;
        int                waited;
        calm             = 1'b0;
        items_sent       = 0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_CLEAR;
        req_ch.address   = '0;
        req_ch.range_end = '0;
        req_ch.new_kind  = 1'b0;
        rst_n            = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty lookup, bad adds, merges, extremes, unused code
        send_item(REQ_LOOKUP, 64'd100, '0, 1'b0);
        send_item(REQ_ADD, '0, 64'd50, 1'b0);
        send_item(REQ_ADD, 64'd80, 64'd80, 1'b0);
        send_item(REQ_ADD, 64'd90, 64'd20, 1'b1);
        send_item(REQ_ADD, 64'd100, 64'd200, 1'b0);
        send_item(REQ_ADD, 64'd200, 64'd300, 1'b0);
        send_item(REQ_ADD, 64'd150, 64'd250, 1'b0);
        send_item(REQ_ADD, 64'd300, 64'd400, 1'b1);
        send_item(REQ_ADD, 64'd500, 64'd600, 1'b1);
        send_item(REQ_ADD, 64'h8000_0000_0000_0000, '1, 1'b0);
        send_item(REQ_LOOKUP, 64'd99, '0, 1'b0);
        send_item(REQ_LOOKUP, 64'd100, '0, 1'b0);
        send_item(REQ_LOOKUP, 64'd299, '0, 1'b0);
        send_item(REQ_LOOKUP, 64'd299, '1, 1'b1);
        send_item(REQ_LOOKUP, 64'd450, '0, 1'b0);
        send_item(REQ_LOOKUP, 64'd599, '0, 1'b0);
        send_item(REQ_LOOKUP, '1, '0, 1'b0);
        send_item(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0);
        send_item(REQ_LOOKUP, '0, '0, 1'b0);
        send_item(2'd3, '1, '1, 1'b1);
        send_item(REQ_CLEAR, '1, '1, 1'b1);
        send_item(REQ_LOOKUP, 64'd150, '0, 1'b0);

        // Fill the table to the brim without idling, then overflow it
        calm   = 1'b1;
        cursor = 64'd16;
        for (int i = 0; i < DEFAULT_TABLE_DEPTH; i++)
        begin
            send_item(REQ_ADD, cursor, cursor + 8, i[0]);
            cursor += 16;
        end
        calm = 1'b0;
        send_item(REQ_ADD, cursor, cursor + 8, 1'b0);
        send_item(REQ_ADD, cursor - 10, cursor + 4, 1'b1);
        send_item(REQ_ADD, cursor + 64, cursor + 80, 1'b1);
        for (int i = 0; i < 8; i++)
            send_lookup();
        send_item(REQ_CLEAR, '0, '0, 1'b0);

        // Random episodes: clear most times, build a small chained table, probe it
        while (items_sent < 1050)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0)
                send_item(REQ_CLEAR, wide_random(), wide_random(), $urandom_range(0, 1));
            cursor = ($urandom_range(0, 7) == 0) ? wide_random() >> 1 : $urandom_range(1, 2000);
            n = $urandom_range(1, 24);
            k = $urandom_range(0, 1);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    k = ~k;
                case ($urandom_range(0, 9))
                    0: begin a = wide_random(); e = wide_random(); end
                    1: begin a = cursor; e = cursor - $urandom_range(0, 3); end
                    2: begin a = '0; e = cursor; end
                    default:
                    begin
                        a = cursor + $urandom_range(0, 4);
                        if ($urandom_range(0, 3) == 0)
                            a = cursor - $urandom_range(0, 30);
                        e = a + $urandom_range(1, 64);
                    end
                endcase
                send_item(REQ_ADD, a, e, k);
                if (e > cursor)
                    cursor = e;
                if ($urandom_range(0, 4) == 0)
                    send_lookup();
            end
            n = $urandom_range(4, 30);
            for (int i = 0; i < n; i++)
                send_lookup();
            if ($urandom_range(0, 9) == 0)
                send_item(2'd3, wide_random(), wide_random(), $urandom_range(0, 1));
        end

        // Drain
        @(negedge clk);
        req_ch.valid = 1'b0;
        waited = 0;
        while (pending_count != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("coalescing_region_kind_table_unit_test: clean");
        else
            $display("coalescing_region_kind_table_unit_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crk_pkg.sv
rtl/crk_if.sv
rtl/crk_front.sv
rtl/crk_back.sv
rtl/coalescing_region_kind_table_unit.sv
bench/crk_table_checker.sv
bench/coalescing_region_kind_table_unit_test.sv
